[rtl/mmb_pkg.sv]
// Package for the MMB block cipher: block and transfer types, round constants
// and the word-level helper functions. No dependencies.
`default_nettype none

package mmb_pkg;

    typedef logic [3:0][31:0] t_words;

    typedef struct packed {
        logic        operation;
        logic [31:0] in_word0;
        logic [31:0] in_word1;
        logic [31:0] in_word2;
        logic [31:0] in_word3;
    } t_in;

    typedef struct packed {
        logic [31:0] out_word0;
        logic [31:0] out_word1;
        logic [31:0] out_word2;
        logic [31:0] out_word3;
    } t_out;

    typedef struct packed {
        logic   op;
        t_words w;
    } t_state;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    localparam int ROUNDS = 6;

    localparam t_words GAMMA = {32'h2F8E6D81, 32'h12F8E6D8, 32'h04BE39B6, 32'h025F1CDB};
    localparam t_words AMMAG = {32'h281B5A8D, 32'h81B5A8D2, 32'h06D6A34A, 32'h0DAD4694};
    localparam logic [31:0] DELTA = 32'h2AAAAAAA;

    function automatic t_words f_mix(input t_words w);
        logic [31:0] t0;
        logic [31:0] t1;
        t_words      r;
        t0   = w[0] ^ w[2];
        t1   = w[1] ^ w[3];
        r[0] = w[0] ^ t1;
        r[1] = w[1] ^ t0;
        r[2] = w[2] ^ t1;
        r[3] = w[3] ^ t0;
        return r;
    endfunction

    function automatic t_words f_delta(input t_words w);
        t_words r;
        r = w;
        if (w[0][0]) begin
            r[0] = w[0] ^ DELTA;
        end
        if (!w[3][0]) begin
            r[3] = w[3] ^ DELTA;
        end
        return r;
    endfunction

    function automatic logic [31:0] f_fold(input logic [63:0] p);
        logic [32:0] s1;
        logic [31:0] s2;
        s1 = {1'b0, p[31:0]} + {1'b0, p[63:32]};
        s2 = s1[31:0] + {31'b0, s1[32]};
        return s2;
    endfunction

    function automatic t_words f_rot_key(input t_words key, input logic [1:0] rot);
        t_words     r;
        logic [1:0] idx;
        for (int i = 0; i < 4; i++) begin
            idx  = 2'(i) + rot;
            r[i] = key[idx];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/mmb_block_cipher_top.sv]
// MMB block cipher, 128-bit block and key: a twelve-stage round pipeline fed
// by the key registers, with a registered final key addition. Depends on mmb_pkg.
//
// The engine takes one block per clock while the output side does not stall.
// There are six rounds of two register stages each, then the output register.
// The first stage of a round does the key addition and the 32 by 32 multiply;
// when decrypting, it also does the word mix and delta step ahead of the
// multiply. The second stage does the fold modulo 2^32-1 and, when encrypting,
// the delta step and word mix. An output register holds the last key addition.
// Every stage has its own valid bit, so a stall at the output fills empty
// stages upstream before the input side stops. The user must write the key
// through the APB port only while no block is in flight; it is not enforced.
`default_nettype none

module mmb_block_cipher_top
    import mmb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_in         i_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_out             o_data
);

    t_words key;
    t_state s_data  [0:ROUNDS];
    logic   s_valid [0:ROUNDS];
    logic   s_ready [0:ROUNDS];
    logic   r_o_valid;
    t_out   r_o_data;
    t_words fin_key;
    t_words fin_words;

    mmb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_key   (key)
    );

    assign s_valid[0]   = i_valid;
    assign s_data[0].op = i_data.operation;
    assign s_data[0].w  = {i_data.in_word3, i_data.in_word2, i_data.in_word1, i_data.in_word0};
    assign o_ready      = s_ready[0];

    for (genvar j = 0; j < ROUNDS; j++) begin : g_round
        localparam logic [1:0] ENC_ROT = 2'(j % 4);
        localparam logic [1:0] DEC_ROT = 2'((ROUNDS - j) % 4);

        mmb_round u_round (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_key_enc (f_rot_key(key, ENC_ROT)),
            .i_key_dec (f_rot_key(key, DEC_ROT)),
            .i_valid   (s_valid[j]),
            .o_ready   (s_ready[j]),
            .i_data    (s_data[j]),
            .o_valid   (s_valid[j+1]),
            .i_ready   (s_ready[j+1]),
            .o_data    (s_data[j+1])
        );
    end

    assign s_ready[ROUNDS] = !r_o_valid || i_ready;

    always_comb begin
        if (s_data[ROUNDS].op == OP_DECRYPT) begin
            fin_key = f_rot_key(key, 2'(0));
        end else begin
            fin_key = f_rot_key(key, 2'(ROUNDS % 4));
        end
        fin_words = s_data[ROUNDS].w ^ fin_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s_ready[ROUNDS]) begin
            r_o_valid <= s_valid[ROUNDS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_ready[ROUNDS] && s_valid[ROUNDS]) begin
            r_o_data.out_word0 <= fin_words[0];
            r_o_data.out_word1 <= fin_words[1];
            r_o_data.out_word2 <= fin_words[2];
            r_o_data.out_word3 <= fin_words[3];
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

endmodule

`default_nettype wire

[rtl/mmb_cfg.sv]
// APB-style key register file for the MMB block cipher.
// Depends on mmb_pkg for the key word type.
`default_nettype none

module mmb_cfg
    import mmb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output t_words           o_key
);

    t_words r_key;
    logic   wr_en;

    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = r_key[paddr[3:2]];
    assign o_key  = r_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (wr_en) begin
            r_key[paddr[3:2]] <= pwdata;
        end
    end

`ifndef SYNTHESIS
    a_key_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> (r_key[$past(paddr[3:2])] == $past(pwdata)))
        else $error("key register did not take the written value");
`endif

endmodule

`default_nettype wire

[rtl/mmb_round.sv]
// One cipher round as two pipeline stages: key add and modular multiply, then
// fold, delta and mix (in stage one when decrypting). Depends on mmb_pkg.
`default_nettype none

module mmb_round
    import mmb_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_words i_key_enc,
    input  wire t_words i_key_dec,
    input  wire logic   i_valid,
    output logic        o_ready,
    input  wire t_state i_data,
    output logic        o_valid,
    input  wire logic   i_ready,
    output t_state      o_data
);

    logic              r_m_valid;
    logic              r_m_op;
    logic [3:0][63:0]  r_prod;
    logic [3:0][63:0]  n_prod;
    logic              r_l_valid;
    t_state            r_l_data;
    t_state            n_l_data;
    logic              m_ready;
    logic              l_ready;
    t_words            x_key;
    t_words            x_mul;
    t_words            c_mul;
    t_words            f_words;

    assign l_ready = !r_l_valid || i_ready;
    assign m_ready = !r_m_valid || l_ready;
    assign o_ready = m_ready;
    assign o_valid = r_l_valid;
    assign o_data  = r_l_data;

    always_comb begin
        if (i_data.op == OP_DECRYPT) begin
            x_key = i_data.w ^ i_key_dec;
            x_mul = f_delta(f_mix(x_key));
            c_mul = AMMAG;
        end else begin
            x_key = i_data.w ^ i_key_enc;
            x_mul = x_key;
            c_mul = GAMMA;
        end
        for (int i = 0; i < 4; i++) begin
            n_prod[i] = {32'b0, x_mul[i]} * {32'b0, c_mul[i]};
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            f_words[i] = f_fold(r_prod[i]);
        end
        n_l_data.op = r_m_op;
        if (r_m_op == OP_DECRYPT) begin
            n_l_data.w = f_words;
        end else begin
            n_l_data.w = f_mix(f_delta(f_words));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_l_valid <= 1'b0;
        end else begin
            if (m_ready) begin
                r_m_valid <= i_valid;
            end
            if (l_ready) begin
                r_l_valid <= r_m_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_ready && i_valid) begin
            r_m_op <= i_data.op;
            r_prod <= n_prod;
        end
        if (l_ready && r_m_valid) begin
            r_l_data <= n_l_data;
        end
    end

`ifndef SYNTHESIS
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_m_valid)
        else $error("accepted block did not reach the multiply stage");

    a_mul_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !l_ready) |=> (r_m_valid && $stable(r_prod) && $stable(r_m_op)))
        else $error("stalled multiply stage lost its products");

    a_logic_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_l_valid && !i_ready) |=> (r_l_valid && $stable(r_l_data)))
        else $error("stalled round output changed");
`endif

endmodule

`default_nettype wire
